[rtl/core/mtpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtpc_pkg
// Shared codes, constants and pattern helpers for the memory test checker.
// ----------------------------------------------------------------------------
package mtpc_pkg;

    localparam logic [31:0] PAT_K   = 32'h16383245;
    localparam logic [31:0] ALL_ONE = 32'hFFFFFFFF;
    localparam logic [31:0] CHK_LO  = 32'h55555555;
    localparam logic [31:0] CHK_HI  = 32'hAAAAAAAA;
    localparam logic [31:0] LOW_16  = 32'h0000FFFF;

    // largest quotient of a 32-bit word by PAT_K
    localparam int DIV_MAX = 32'hFFFFFFFF / 32'h16383245;

    localparam int MODE_W = 5;
    localparam int PASS_W = 8;

    localparam logic [MODE_W-1:0] MODE_FIXED   = 5'd0;
    localparam logic [MODE_W-1:0] MODE_XOR     = 5'd1;
    localparam logic [MODE_W-1:0] MODE_SUB     = 5'd2;
    localparam logic [MODE_W-1:0] MODE_MUL     = 5'd3;
    localparam logic [MODE_W-1:0] MODE_DIV     = 5'd4;
    localparam logic [MODE_W-1:0] MODE_OR      = 5'd5;
    localparam logic [MODE_W-1:0] MODE_AND     = 5'd6;
    localparam logic [MODE_W-1:0] MODE_SEQINC  = 5'd7;
    localparam logic [MODE_W-1:0] MODE_SOLID   = 5'd8;
    localparam logic [MODE_W-1:0] MODE_CHECKER = 5'd9;
    localparam logic [MODE_W-1:0] MODE_BLOCK   = 5'd10;
    localparam logic [MODE_W-1:0] MODE_WALK    = 5'd11;
    localparam logic [MODE_W-1:0] MODE_SPREAD  = 5'd12;
    localparam logic [MODE_W-1:0] MODE_FLIP    = 5'd13;
    localparam logic [MODE_W-1:0] MODE_ADDR    = 5'd14;
    localparam logic [MODE_W-1:0] MODE_A5FULL  = 5'd15;
    localparam logic [MODE_W-1:0] MODE_A5LOW   = 5'd16;

    localparam logic [1:0] REG_TEST_MODE = 2'd0;
    localparam logic [1:0] REG_WALK_INV  = 2'd1;
    localparam logic [1:0] REG_WORD_CNT  = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    typedef struct packed {
        logic        mismatch;
        logic        pass_done;
        logic        test_done;
        logic        test_failed;
        logic [19:0] failing_word;
        logic [7:0]  pass_number;
    } mtpc_status_t;

    function automatic logic [31:0] bit_at(input logic [PASS_W-1:0] n);
        bit_at = (n < 8'd32) ? (32'd1 << n[4:0]) : 32'd0;
    endfunction

    function automatic logic [31:0] div_k(input logic [31:0] d);
        logic [31:0] q;
        q = 32'd0;
        for (int k = 1; k <= DIV_MAX; k++) begin
            if (64'(d) >= 64'(k) * 64'(PAT_K)) begin
                q = 32'(k);
            end
        end
        div_k = q;
    endfunction

    function automatic logic [PASS_W-1:0] last_pass(input logic [MODE_W-1:0] mode);
        case (mode)
            MODE_SOLID, MODE_CHECKER, MODE_WALK, MODE_SPREAD: last_pass = 8'd63;
            MODE_BLOCK, MODE_FLIP:                            last_pass = 8'd255;
            MODE_ADDR:                                        last_pass = 8'd15;
            default:                                          last_pass = 8'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

[rtl/core/memory_test_pattern_checker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// memory_test_pattern_checker_unit
// Memory self-test engine: write data generation and read checking per word.
// ----------------------------------------------------------------------------
// Channel  Dir  Word
// s_*      in   tuser: command; tdata: word_address, data_a, data_b
// m_*      out  tdata: write_a, write_b, mismatch, pass_done, test_done,
//               test_failed, failing_word, pass_number
// cfg_*    in   cfg_index: register, cfg_data: value
//
// One word per cycle unless the result stalls; the path from input to result is
// input register, pattern logic, result register. The divide test uses a bank of
// constant compares and the multiply test one 32x32 multiplier per data word.
// Reset clears all progress; configuration resets to mode 0, 1024 words.
// A stalled result holds; one more word may wait in the input register.
// A write to the test mode, walk inversion or word count register restarts the test.
// ----------------------------------------------------------------------------
module memory_test_pattern_checker_unit
    import mtpc_pkg::*;
#(
    parameter int MAX_WORDS = 1048576
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // word_address, data_a, data_b
    input  wire logic        s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [95:0] m_tdata,   // write_a, write_b, mismatch, pass_done,
                                        // test_done, test_failed, failing_word,
                                        // pass_number
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int LIM   = (MAX_WORDS > 2097151) ? 2097151 : MAX_WORDS;
    localparam int IDX_W = $clog2(LIM);

    logic [MODE_W-1:0] test_mode_reg;
    logic              walk_inv_reg;
    logic [20:0]       word_cnt_reg;

    logic              in_valid_reg;
    logic              cmd_reg;
    logic [31:0]       addr_reg;
    logic [31:0]       da_reg;
    logic [31:0]       db_reg;

    logic [IDX_W-1:0]  wr_idx_reg;
    logic [IDX_W-1:0]  wr_idx_next;
    logic [IDX_W-1:0]  chk_idx_reg;
    logic [IDX_W-1:0]  chk_idx_next;
    logic [PASS_W-1:0] pass_reg;
    logic [PASS_W-1:0] pass_next;
    logic              failed_reg;
    logic              failed_next;
    logic              done_reg;
    logic              done_next;
    logic [IDX_W-1:0]  fail_idx_reg;
    logic [IDX_W-1:0]  fail_idx_next;

    logic              out_valid_reg;
    logic [95:0]       m_tdata_reg;
    logic [95:0]       m_tdata_next;

    logic              advance;
    logic              fire;
    logic              cfg_hit;
    logic [MODE_W-1:0] mode;
    logic [31:0]       cnt;
    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  cur_idx;
    logic [31:0]       pat_a;
    logic [31:0]       pat_b;
    logic [31:0]       expect_a;
    logic [31:0]       wa;
    logic [31:0]       wb;
    mtpc_status_t      st;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign fire      = in_valid_reg && advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == REG_TEST_MODE
                                  || cfg_index == REG_WALK_INV
                                  || cfg_index == REG_WORD_CNT);

    assign mode = (test_mode_reg > MODE_A5LOW) ? MODE_FIXED : test_mode_reg;

    always_comb
    begin
        if (word_cnt_reg == 21'd0)
            cnt = 32'd1;
        else if (32'(word_cnt_reg) > 32'(LIM))
            cnt = 32'(LIM);
        else
            cnt = 32'(word_cnt_reg);
    end

    assign last_idx = IDX_W'(cnt - 32'd1);
    assign cur_idx  = (cmd_reg == CMD_CHECK) ? chk_idx_reg : wr_idx_reg;

    mtpc_pattern #(
        .IDX_W(IDX_W)
    ) u_pattern (
        .mode         (mode),
        .walk_inverted(walk_inv_reg),
        .word_index   (cur_idx),
        .pass_index   (pass_reg),
        .word_address (addr_reg),
        .data_a       (da_reg),
        .data_b       (db_reg),
        .write_a      (pat_a),
        .write_b      (pat_b)
    );

    assign expect_a = (mode >= MODE_ADDR) ? pat_a : db_reg;

    always_comb
    begin
        wr_idx_next   = wr_idx_reg;
        chk_idx_next  = chk_idx_reg;
        pass_next     = pass_reg;
        failed_next   = failed_reg;
        done_next     = done_reg;
        fail_idx_next = fail_idx_reg;
        wa            = 32'd0;
        wb            = 32'd0;
        st.mismatch   = 1'b0;
        st.pass_done  = 1'b0;
        if (!done_reg)
        begin
            if (cmd_reg == CMD_WRITE)
            begin
                wa          = pat_a;
                wb          = pat_b;
                wr_idx_next = (wr_idx_reg == last_idx) ? '0 : wr_idx_reg + 1'b1;
            end
            else if (da_reg != expect_a)
            begin
                st.mismatch   = 1'b1;
                failed_next   = 1'b1;
                fail_idx_next = chk_idx_reg;
                done_next     = 1'b1;
            end
            else if (chk_idx_reg == last_idx)
            begin
                st.pass_done = 1'b1;
                chk_idx_next = '0;
                wr_idx_next  = '0;
                if (pass_reg == last_pass(mode))
                    done_next = 1'b1;
                else
                    pass_next = pass_reg + 8'd1;
            end
            else
            begin
                chk_idx_next = chk_idx_reg + 1'b1;
            end
        end
        st.test_done    = done_next;
        st.test_failed  = failed_next;
        st.failing_word = 20'(fail_idx_next);
        st.pass_number  = pass_next;
        m_tdata_next    = {st.pass_number, st.failing_word, st.test_failed,
                           st.test_done, st.pass_done, st.mismatch, wb, wa};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            test_mode_reg <= MODE_FIXED;
            walk_inv_reg  <= 1'b0;
            word_cnt_reg  <= 21'd1024;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TEST_MODE: test_mode_reg <= cfg_data[MODE_W-1:0];
                REG_WALK_INV:  walk_inv_reg  <= cfg_data[0];
                REG_WORD_CNT:  word_cnt_reg  <= cfg_data[20:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg   <= '0;
            chk_idx_reg  <= '0;
            pass_reg     <= '0;
            failed_reg   <= 1'b0;
            done_reg     <= 1'b0;
            fail_idx_reg <= '0;
        end
        else if (cfg_hit)
        begin
            wr_idx_reg   <= '0;
            chk_idx_reg  <= '0;
            pass_reg     <= '0;
            failed_reg   <= 1'b0;
            done_reg     <= 1'b0;
            fail_idx_reg <= '0;
        end
        else if (fire)
        begin
            wr_idx_reg   <= wr_idx_next;
            chk_idx_reg  <= chk_idx_next;
            pass_reg     <= pass_next;
            failed_reg   <= failed_next;
            done_reg     <= done_next;
            fail_idx_reg <= fail_idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg  <= s_tuser;
            addr_reg <= s_tdata[31:0];
            da_reg   <= s_tdata[63:32];
            db_reg   <= s_tdata[95:64];
        end
        if (fire)
            m_tdata_reg <= m_tdata_next;
    end

endmodule
`default_nettype wire

[rtl/core/mtpc_pattern.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtpc_pattern
// Write data and address-test pattern for one word slot.
// ----------------------------------------------------------------------------
module mtpc_pattern
    import mtpc_pkg::*;
#(
    parameter int IDX_W = 20
)
(
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic              walk_inverted,
    input  wire logic [IDX_W-1:0]  word_index,
    input  wire logic [PASS_W-1:0] pass_index,
    input  wire logic [31:0]       word_address,
    input  wire logic [31:0]       data_a,
    input  wire logic [31:0]       data_b,
    output logic      [31:0]       write_a,
    output logic      [31:0]       write_b
);

    logic              odd;
    logic [31:0]       q;
    logic [31:0]       fix;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [PASS_W-1:0] j;

    assign j     = pass_index;
    assign odd   = word_index[0];
    assign mul_a = data_a * PAT_K;
    assign mul_b = data_b * PAT_K;

    always_comb
    begin
        q = 32'd0;
        case (mode)
            MODE_SEQINC:  fix = 32'(word_index) + PAT_K;
            MODE_SOLID:
            begin
                q   = j[0] ? 32'd0 : ALL_ONE;
                fix = odd ? ~q : q;
            end
            MODE_CHECKER:
            begin
                q   = j[0] ? CHK_HI : CHK_LO;
                fix = odd ? ~q : q;
            end
            MODE_BLOCK:   fix = 32'(j);
            MODE_WALK:
            begin
                q   = bit_at((j < 8'd32) ? j : 8'd63 - j);
                fix = walk_inverted ? ~q : q;
            end
            MODE_SPREAD:
            begin
                q   = (j < 8'd32) ? (bit_at(j) | bit_at(j + 8'd2))
                                  : (bit_at(8'd63 - j) | bit_at(8'd65 - j));
                fix = odd ? ~q : q;
            end
            default:
            begin
                q   = bit_at({3'd0, j[7:3]});
                q   = j[0] ? q : ~q;
                fix = odd ? ~q : q;
            end
        endcase
    end

    always_comb
    begin
        unique case (mode)
            MODE_FIXED:
            begin
                write_a = PAT_K;
                write_b = PAT_K;
            end
            MODE_XOR:
            begin
                write_a = data_a ^ PAT_K;
                write_b = data_b ^ PAT_K;
            end
            MODE_SUB:
            begin
                write_a = data_a - PAT_K;
                write_b = data_b - PAT_K;
            end
            MODE_MUL:
            begin
                write_a = mul_a;
                write_b = mul_b;
            end
            MODE_DIV:
            begin
                write_a = div_k(data_a);
                write_b = div_k(data_b);
            end
            MODE_OR:
            begin
                write_a = data_a | PAT_K;
                write_b = data_b | PAT_K;
            end
            MODE_AND:
            begin
                write_a = data_a & PAT_K;
                write_b = data_b & PAT_K;
            end
            MODE_ADDR:
            begin
                write_a = (j[0] ^ word_index[0]) ? ~word_address : word_address;
                write_b = 32'd0;
            end
            MODE_A5FULL:
            begin
                write_a = word_address[5] ? ALL_ONE : 32'd0;
                write_b = 32'd0;
            end
            MODE_A5LOW:
            begin
                write_a = word_address[5] ? LOW_16 : 32'd0;
                write_b = 32'd0;
            end
            default:
            begin
                write_a = fix;
                write_b = fix;
            end
        endcase
    end

endmodule
`default_nettype wire

[tb/memory_test_pattern_checker_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_test_pattern_checker_unit_tb
// Self-checking bench for the memory test pattern checker. A scoreboard
// class tracks test mode, word count and pass progress, predicts the status
// word for every accepted slot and compares each result field by field.
// Directed slots hit the data extremes and the edge cases, then randomised
// test runs over all modes go through clean and faulty pass sequences under
// varying handshake back-pressure.
// ----------------------------------------------------------------------------
module memory_test_pattern_checker_unit_tb;
    import mtpc_pkg::*;

    localparam int MAX_WORDS    = 1048576;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int ITEMS_TOTAL  = 2000;

    localparam logic [1:0] REG_SPARE = 2'd3;

    class pattern_scoreboard;
        bit [4:0]    mode_reg;
        bit          walk_inv;
        bit [20:0]   count_reg;
        int unsigned wr_idx;
        int unsigned chk_idx;
        int unsigned pass_idx;
        int unsigned fail_idx;
        bit          failed;
        bit          done;
        bit [95:0]   pending_status[$];
        int          errors;
        int          results;
        int          words;
        int          passes_closed;
        int          tests_ended;
        int          faults_caught;

        function new();
            mode_reg  = MODE_FIXED;
            walk_inv  = 1'b0;
            count_reg = 21'd1024;
            clear_progress();
        endfunction

        function void clear_progress();
            wr_idx   = 0;
            chk_idx  = 0;
            pass_idx = 0;
            fail_idx = 0;
            failed   = 1'b0;
            done     = 1'b0;
        endfunction

        function void apply_reg(bit [1:0] idx, bit [31:0] val);
            case (idx)
                REG_TEST_MODE: mode_reg  = val[4:0];
                REG_WALK_INV:  walk_inv  = val[0];
                REG_WORD_CNT:  count_reg = val[20:0];
                default:       return;
            endcase
            clear_progress();
        endfunction

        function bit [4:0] eff_mode();
            return (mode_reg > MODE_A5LOW) ? MODE_FIXED : mode_reg;
        endfunction

        function int unsigned eff_count();
            int unsigned c;
            c = count_reg;
            if (c == 0) c = 1;
            if (c > MAX_WORDS) c = MAX_WORDS;
            return c;
        endfunction

        function int unsigned pass_count(bit [4:0] m);
            case (m)
                MODE_SOLID, MODE_CHECKER, MODE_WALK, MODE_SPREAD: return 64;
                MODE_BLOCK, MODE_FLIP:                            return 256;
                MODE_ADDR:                                        return 16;
                default:                                          return 1;
            endcase
        endfunction

        function bit [31:0] single_bit(int unsigned n);
            return (n < 32) ? (32'd1 << n) : 32'd0;
        endfunction

        function bit [31:0] addr_word(bit [4:0] m, bit [31:0] a, int unsigned i,
                                      int unsigned j);
            if (m == MODE_ADDR) return (((i + j) & 1) == 0) ? a : ~a;
            if (m == MODE_A5FULL) return a[5] ? ALL_ONE : 32'd0;
            return a[5] ? LOW_16 : 32'd0;
        endfunction

        function bit [31:0] fixed_word(bit [4:0] m, int unsigned i, int unsigned j);
            bit [31:0]   q;
            int unsigned s;
            bit          odd;
            odd = i[0];
            case (m)
                MODE_SEQINC:  return i + PAT_K;
                MODE_SOLID:   q = j[0] ? 32'd0 : ALL_ONE;
                MODE_CHECKER: q = j[0] ? CHK_HI : CHK_LO;
                MODE_BLOCK:   return j;
                MODE_WALK:
                begin
                    s = (j < 32) ? j : 63 - j;
                    q = single_bit(s);
                    return walk_inv ? ~q : q;
                end
                MODE_SPREAD:
                begin
                    if (j < 32) q = single_bit(j) | single_bit(j + 2);
                    else q = single_bit(63 - j) | single_bit(65 - j);
                end
                default:
                begin
                    q = single_bit((j >> 3) & 31);
                    if (!j[0]) q = ~q;
                end
            endcase
            return odd ? ~q : q;
        endfunction

        function void predict_slot(bit cmd, bit [31:0] a, bit [31:0] da, bit [31:0] db);
            bit [4:0]    m;
            int unsigned cnt;
            bit [31:0]   wa;
            bit [31:0]   wb;
            bit [31:0]   want_a;
            bit          mis;
            bit          pdone;
            m     = eff_mode();
            cnt   = eff_count();
            wa    = 32'd0;
            wb    = 32'd0;
            mis   = 1'b0;
            pdone = 1'b0;
            words++;
            if (!done) begin
                if (cmd == CMD_WRITE) begin
                    case (m)
                        MODE_FIXED: begin wa = PAT_K; wb = PAT_K; end
                        MODE_XOR:   begin wa = da ^ PAT_K; wb = db ^ PAT_K; end
                        MODE_SUB:   begin wa = da - PAT_K; wb = db - PAT_K; end
                        MODE_MUL:   begin wa = da * PAT_K; wb = db * PAT_K; end
                        MODE_DIV:   begin wa = da / PAT_K; wb = db / PAT_K; end
                        MODE_OR:    begin wa = da | PAT_K; wb = db | PAT_K; end
                        MODE_AND:   begin wa = da & PAT_K; wb = db & PAT_K; end
                        MODE_ADDR, MODE_A5FULL, MODE_A5LOW:
                            wa = addr_word(m, a, wr_idx, pass_idx);
                        default:
                        begin
                            wa = fixed_word(m, wr_idx, pass_idx);
                            wb = wa;
                        end
                    endcase
                    wr_idx = (wr_idx + 1 >= cnt) ? 0 : wr_idx + 1;
                end else begin
                    want_a = (m >= MODE_ADDR) ? addr_word(m, a, chk_idx, pass_idx) : db;
                    if (da != want_a) begin
                        mis      = 1'b1;
                        failed   = 1'b1;
                        fail_idx = chk_idx;
                        done     = 1'b1;
                        faults_caught++;
                        tests_ended++;
                    end else if (chk_idx + 1 >= cnt) begin
                        pdone   = 1'b1;
                        chk_idx = 0;
                        wr_idx  = 0;
                        passes_closed++;
                        if (pass_idx + 1 >= pass_count(m)) begin
                            done = 1'b1;
                            tests_ended++;
                        end else begin
                            pass_idx++;
                        end
                    end else begin
                        chk_idx++;
                    end
                end
            end
            pending_status.push_back({pass_idx[7:0], fail_idx[19:0], failed, done,
                                      pdone, mis, wb, wa});
        endfunction

        function void check_status(bit [95:0] got);
            bit [95:0] want;
            bit [95:0] mask;
            bit        bad;
            string     fname[8];
            int        lo[8];
            int        wid[8];
            fname = '{"write_a", "write_b", "mismatch", "pass_done", "test_done",
                      "test_failed", "failing_word", "pass_number"};
            lo    = '{0, 32, 64, 65, 66, 67, 68, 88};
            wid   = '{32, 32, 1, 1, 1, 1, 20, 8};
            if (pending_status.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result word %0h with nothing expected", got);
                return;
            end
            want = pending_status.pop_front();
            bad  = 1'b0;
            for (int k = 0; k < 8; k++) begin
                mask = {96{1'b1}} >> (96 - wid[k]);
                if (((got >> lo[k]) & mask) != ((want >> lo[k]) & mask)) begin
                    if (!bad) errors++;
                    bad = 1'b1;
                    if (errors <= 10)
                        $display("result %0d %s: expected %0h got %0h", results, fname[k],
                                 (want >> lo[k]) & mask, (got >> lo[k]) & mask);
                end
            end
            results++;
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;   // word_address, data_a, data_b
    logic        s_tuser   = 1'b0; // command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;          // write_a, write_b, mismatch, pass_done,
                                   // test_done, test_failed, failing_word,
                                   // pass_number
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    pattern_scoreboard sb;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_req     = 1'b0;
    int cycles       = 0;
    int test_runs    = 0;

    memory_test_pattern_checker_unit #(
        .MAX_WORDS (MAX_WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: sample, then choose next tready
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) sb.check_status(m_tdata);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic send_word(bit cmd, bit [31:0] a, bit [31:0] da, bit [31:0] db);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {db, da, a};
        do @(posedge clk); while (!s_tready);
        sb.predict_slot(cmd, a, da, db);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending_status.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        sb.apply_reg(idx, val);
    endtask

    task automatic random_test(inout int left);
        int unsigned r;
        int unsigned mode;
        int unsigned cnt;
        int          budget;
        int          fault_pm;
        bit          cmd;
        bit [31:0]   a;
        bit [31:0]   da;
        bit [31:0]   db;
        settle();
        r    = $urandom_range(19);
        mode = (r < 17) ? r : $urandom_range(31, 17);
        r    = $urandom_range(19);
        if (r == 0) cnt = 0;
        else if (r == 1) cnt = 21'h1FFFFF;
        else if (r == 2) cnt = MAX_WORDS;
        else if (r < 12) cnt = 1;
        else cnt = $urandom_range(5, 2);
        write_reg(REG_TEST_MODE, ($urandom & ~32'h1F) | mode);
        write_reg(REG_WALK_INV, ($urandom & ~32'h1) | $urandom_range(1));
        write_reg(REG_WORD_CNT, ($urandom & ~32'h1FFFFF) | cnt);
        test_runs++;
        budget   = (cnt > 5) ? $urandom_range(40, 10) : $urandom_range(480, 40);
        fault_pm = ($urandom_range(9) < 6) ? 0 : 20;
        if (budget > left) budget = left;
        while (budget > 0 && !sb.done)
        begin
            cmd = ($urandom_range(99) < 60) ? CMD_CHECK : CMD_WRITE;
            a   = $urandom;
            da  = $urandom;
            db  = $urandom;
            if (cmd == CMD_CHECK) begin
                if (sb.eff_mode() >= MODE_ADDR)
                    da = sb.addr_word(sb.eff_mode(), a, sb.chk_idx, sb.pass_idx);
                else
                    da = db;
                if ($urandom_range(999) < fault_pm) begin
                    if ($urandom_range(1)) da = da ^ (32'd1 << $urandom_range(31));
                    else da = $urandom;
                end
            end
            send_word(cmd, a, da, db);
            budget--;
            left--;
        end
        // a few slots after the end, which must leave the state alone
        if (sb.done)
            repeat ($urandom_range(2)) send_word($urandom_range(1), $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        int left;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default setup: extremes, then a failing check ends the test
        send_word(CMD_WRITE, 32'd0, 32'd0, 32'd0);
        send_word(CMD_WRITE, ALL_ONE, ALL_ONE, ALL_ONE);
        send_word(CMD_CHECK, 32'd0, ALL_ONE, ALL_ONE);
        send_word(CMD_CHECK, ALL_ONE, 32'd0, ALL_ONE);
        send_word(CMD_WRITE, 32'd0, ALL_ONE, 32'd0);
        send_word(CMD_CHECK, 32'd0, 32'd0, 32'd0);
        settle();
        write_reg(REG_SPARE, ALL_ONE);
        send_word(CMD_CHECK, 32'd0, 32'd5, 32'd5);
        settle();
        write_reg(REG_TEST_MODE, MODE_DIV);
        send_word(CMD_WRITE, 32'd0, ALL_ONE, 32'd0);
        send_word(CMD_WRITE, 32'd0, PAT_K, PAT_K - 32'd1);
        settle();
        // address bit 5, low half; zero word count acts as one word
        write_reg(REG_TEST_MODE, MODE_A5LOW);
        write_reg(REG_WORD_CNT, 32'd0);
        send_word(CMD_WRITE, 32'h0000_0020, ALL_ONE, ALL_ONE);
        send_word(CMD_CHECK, 32'hFFFF_FFDF, 32'd0, ALL_ONE);
        send_word(CMD_WRITE, 32'h0000_0020, 32'd0, 32'd0);
        settle();
        // unused mode number, oversize word count
        write_reg(REG_TEST_MODE, 32'd31);
        write_reg(REG_WORD_CNT, ALL_ONE);
        write_reg(REG_WALK_INV, 32'd1);
        send_word(CMD_WRITE, ALL_ONE, ALL_ONE, ALL_ONE);
        send_word(CMD_CHECK, ALL_ONE, 32'h8000_0001, 32'h8000_0001);
        settle();
        // multiply with wrap of the write pointer
        write_reg(REG_TEST_MODE, MODE_MUL);
        write_reg(REG_WORD_CNT, 32'd2);
        send_word(CMD_WRITE, 32'd0, ALL_ONE, 32'h8000_0001);
        send_word(CMD_WRITE, 32'd0, 32'd0, ALL_ONE);
        send_word(CMD_WRITE, 32'd0, 32'h1234_5678, 32'd1);
        send_word(CMD_CHECK, 32'd0, 32'd7, 32'd7);
        send_word(CMD_CHECK, 32'd0, ALL_ONE, ALL_ONE);

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 66 : 0;
            snk_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 22 : 0;
            left = (ph == 2) ? ITEMS_TOTAL - 2 * (ITEMS_TOTAL / 3) : ITEMS_TOTAL / 3;
            hold_req = 1'b1;
            while (left > 0) random_test(left);
        end

        settle();
        $display("%0d slots over %0d random test runs, %0d results checked",
                 sb.words, test_runs, sb.results);
        $display("%0d passes closed, %0d tests ended, %0d on a detected fault",
                 sb.passes_closed, sb.tests_ended, sb.faults_caught);
        if (sb.errors == 0 && sb.pending_status.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[memory_test_pattern_checker_unit.f]
rtl/core/mtpc_pkg.sv
rtl/core/mtpc_pattern.sv
rtl/core/memory_test_pattern_checker_unit.sv
tb/memory_test_pattern_checker_unit_tb.sv
